FILE: rtl/cfrq_pkg.sv
`default_nettype none

package cfrq_pkg;

    localparam int FRAME_LENGTH = 7;
    localparam int FRAME_BITS   = 8 * FRAME_LENGTH;
    localparam int BYTE_IDX_W   = 3;

    localparam logic [7:0] START_BYTE = 8'h53;
    localparam logic [7:0] END_BYTE   = 8'hFE;
    localparam logic [7:0] ADDR_BYTE  = 8'h01;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [7:0] CMD_BASE   = 8'h54;
    localparam logic [2:0] CMD_NONE   = 3'd0;

    localparam logic [BYTE_IDX_W-1:0] LAST_BYTE_IDX = BYTE_IDX_W'(FRAME_LENGTH - 1);

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_QUEUED  = 3'd1,
        EV_DROPPED = 3'd2,
        EV_EMPTY   = 3'd3,
        EV_BAD_HDR = 3'd4,
        EV_BAD_CMD = 3'd5,
        EV_ACCEPT  = 3'd6
    } event_t;

endpackage

`default_nettype wire

FILE: rtl/command_frame_receiver_queue.sv
// a result passes through the middle stage and then the result register after its item is accepted
// throughput: one item per cycle unless item_stall holds it; the queue memory is read once per item
// pointers, fill count and frame assembly update in the accept cycle
// reset (rst_n low, asynchronous) clears assembly, pointers, fill count and valids
// queue memory and partial frame bytes are not cleared; only written entries are popped
`default_nettype none

module command_frame_receiver_queue
    import cfrq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 10
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   item_valid,
    output logic                                        item_stall,
    input  wire logic                                   kind,
    input  wire logic [7:0]                             rx_byte,
    output logic                                        result_valid,
    input  wire logic                                   result_stall,
    output logic [2:0]                                  event_res,
    output logic [2:0]                                  command,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]            queue_count
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    // control state
    logic                  assembling_reg, assembling_next;
    logic [BYTE_IDX_W-1:0] byte_count_reg, byte_count_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]      held_reg, held_next;

    // partial frame, last byte goes straight into the queue
    logic [7:0] frame_bytes_reg [FRAME_LENGTH-1];
    logic                  fb_we;
    logic [BYTE_IDX_W-1:0] fb_idx;

    logic [FRAME_BITS-1:0] queue_mem [QUEUE_DEPTH];
    logic [FRAME_BITS-1:0] rd_data_reg;
    logic [FRAME_BITS-1:0] wr_data;
    logic                  mem_we;

    // middle stage
    logic             s1_valid_reg;
    logic             s1_check_reg, s1_check_next;
    event_t           s1_event_reg, s1_event_next;
    logic [CNT_W-1:0] s1_count_reg;

    // result register
    logic             out_valid_reg;
    event_t           out_event_reg, out_event_next;
    logic [2:0]       out_cmd_reg, out_cmd_next;
    logic [CNT_W-1:0] out_count_reg;

    logic accept;
    logic out_ready;
    logic s1_advance;

    assign out_ready  = !out_valid_reg || !result_stall;
    assign s1_advance = s1_valid_reg && out_ready;
    assign item_stall = s1_valid_reg && !out_ready;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        assembling_next = assembling_reg;
        byte_count_next = byte_count_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        held_next       = held_reg;
        fb_we           = 1'b0;
        fb_idx          = byte_count_reg;
        mem_we          = 1'b0;
        s1_check_next   = 1'b0;
        s1_event_next   = EV_NONE;

        if (!kind)
        begin
            if (!assembling_reg)
            begin
                if (rx_byte == START_BYTE)
                begin
                    fb_we           = 1'b1;
                    fb_idx          = '0;
                    byte_count_next = BYTE_IDX_W'(1);
                    assembling_next = 1'b1;
                end
                else
                begin
                    byte_count_next = '0;
                end
            end
            else if (byte_count_reg == LAST_BYTE_IDX)
            begin
                assembling_next = 1'b0;
                byte_count_next = '0;
                if (held_reg == CNT_FULL)
                begin
                    s1_event_next = EV_DROPPED;
                end
                else
                begin
                    mem_we        = 1'b1;
                    wr_ptr_next   = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
                    held_next     = held_reg + 1'b1;
                    s1_event_next = EV_QUEUED;
                end
            end
            else
            begin
                fb_we           = 1'b1;
                byte_count_next = byte_count_reg + 1'b1;
            end
        end
        else
        begin
            if (held_reg == '0)
            begin
                s1_event_next = EV_EMPTY;
            end
            else
            begin
                rd_ptr_next   = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
                held_next     = held_reg - 1'b1;
                s1_check_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        wr_data = '0;
        for (int i = 0; i < FRAME_LENGTH - 1; i++)
        begin
            wr_data[8*i +: 8] = frame_bytes_reg[i];
        end
        wr_data[8*(FRAME_LENGTH-1) +: 8] = rx_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            assembling_reg <= 1'b0;
            byte_count_reg <= '0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            held_reg       <= '0;
        end
        else if (accept)
        begin
            assembling_reg <= assembling_next;
            byte_count_reg <= byte_count_next;
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            held_reg       <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && fb_we)
        begin
            frame_bytes_reg[fb_idx] <= rx_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && mem_we)
        begin
            queue_mem[wr_ptr_reg] <= wr_data;
        end
    end

    // read the head entry on every beat, only used for a pop
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= queue_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_check_reg <= s1_check_next;
            s1_event_reg <= s1_event_next;
            s1_count_reg <= held_next;
        end
    end

    // frame check on the popped entry
    always_comb
    begin
        logic [7:0] b0, b1, b2, b3, b4, b5, b6;
        b0 = rd_data_reg[7:0];
        b1 = rd_data_reg[15:8];
        b2 = rd_data_reg[23:16];
        b3 = rd_data_reg[31:24];
        b4 = rd_data_reg[39:32];
        b5 = rd_data_reg[47:40];
        b6 = rd_data_reg[55:48];

        out_event_next = s1_event_reg;
        out_cmd_next   = CMD_NONE;
        if (s1_check_reg)
        begin
            if (b0 != START_BYTE || b2 != ADDR_BYTE || b3 != ZERO_BYTE ||
                b4 != ZERO_BYTE || b6 != END_BYTE)
            begin
                out_event_next = EV_BAD_HDR;
            end
            else if (b1 == ZERO_BYTE || b1[7:3] != 5'd0 || b5 != (CMD_BASE + b1))
            begin
                out_event_next = EV_BAD_CMD;
            end
            else
            begin
                out_event_next = EV_ACCEPT;
                out_cmd_next   = b1[2:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_event_reg <= out_event_next;
            out_cmd_reg   <= out_cmd_next;
            out_count_reg <= s1_count_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign event_res    = out_event_reg;
    assign command      = out_cmd_reg;
    assign queue_count  = out_count_reg;

endmodule

`default_nettype wire

FILE: bench/command_frame_receiver_queue_test.sv
`timescale 1ns / 100ps

import cfrq_pkg::*;

typedef logic [7:0] frame_t [FRAME_LENGTH];

typedef struct packed {
    event_t     ev;
    logic [2:0] cmd;
    logic [3:0] count;
} outcome_t;

// shadow copy of the assembler and frame queue, plus the outcomes still owed
class frame_queue_shadow #(int DEPTH = 10);
    bit       assembling;
    int       byte_count;
    frame_t   partial;
    frame_t   stored [DEPTH];
    int       rd_ptr;
    int       wr_ptr;
    int       frames_held;
    outcome_t awaited [$];
    int       errors;

    function new();
        assembling  = 1'b0;
        byte_count  = 0;
        rd_ptr      = 0;
        wr_ptr      = 0;
        frames_held = 0;
        errors      = 0;
    endfunction

    function int pending();
        return awaited.size();
    endfunction

    task report_mismatch(string msg);
        $display("%0t ns: %s", $time, msg);
        errors++;
    endtask

    function event_t absorb_byte(logic [7:0] b);
        if (!assembling)
        begin
            if (b == START_BYTE)
            begin
                partial[0] = b;
                byte_count = 1;
                assembling = 1'b1;
            end
            else
                byte_count = 0;
            return EV_NONE;
        end
        partial[byte_count] = b;
        byte_count++;
        if (byte_count < FRAME_LENGTH)
            return EV_NONE;
        assembling = 1'b0;
        byte_count = 0;
        if (frames_held >= DEPTH)
            return EV_DROPPED;
        stored[wr_ptr] = partial;
        wr_ptr = (wr_ptr + 1 == DEPTH) ? 0 : wr_ptr + 1;
        frames_held++;
        return EV_QUEUED;
    endfunction

    function event_t pop_oldest(output logic [2:0] cmd);
        frame_t f;
        cmd = CMD_NONE;
        if (frames_held == 0)
            return EV_EMPTY;
        f = stored[rd_ptr];
        rd_ptr = (rd_ptr + 1 == DEPTH) ? 0 : rd_ptr + 1;
        frames_held--;
        if (f[0] != START_BYTE || f[2] != ADDR_BYTE || f[3] != ZERO_BYTE ||
            f[4] != ZERO_BYTE || f[6] != END_BYTE)
            return EV_BAD_HDR;
        if (f[1] < 8'd1 || f[1] > 8'd7 || f[5] != 8'(CMD_BASE + f[1]))
            return EV_BAD_CMD;
        cmd = f[1][2:0];
        return EV_ACCEPT;
    endfunction

    function void log_item(bit k, logic [7:0] b);
        outcome_t   o;
        logic [2:0] c;
        c = CMD_NONE;
        if (!k)
            o.ev = absorb_byte(b);
        else
            o.ev = pop_oldest(c);
        o.cmd   = c;
        o.count = 4'(frames_held);
        awaited.push_back(o);
    endfunction

    task check_event(logic [2:0] ev, logic [2:0] cmd, logic [3:0] count);
        outcome_t w;
        if (awaited.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing owed: event %0d", ev));
            return;
        end
        w = awaited.pop_front();
        if (ev !== w.ev)
            report_mismatch($sformatf("event_res %0d, wanted %0d", ev, w.ev));
        if (cmd !== w.cmd)
            report_mismatch($sformatf("command %0d, wanted %0d", cmd, w.cmd));
        if (count !== w.count)
            report_mismatch($sformatf("queue_count %0d, wanted %0d", count, w.count));
    endtask
endclass

module command_frame_receiver_queue_test;

    localparam int QDEPTH      = 10;
    localparam int HOLD_CYCLES = 150;
    localparam int DRAIN       = 8;
    localparam int LIMIT       = 250000;
    localparam int CHUNK_ITEMS = 100;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    logic kind = 1'b0;
    logic [7:0] rx_byte = 8'h00;
    logic result_valid;
    logic result_stall = 1'b0;
    logic [2:0] event_res;
    logic [2:0] command;
    logic [$clog2(QDEPTH+1)-1:0] queue_count;

    frame_queue_shadow #(QDEPTH) shadow;
    bit calm_phase = 1'b0;
    bit hold_request = 1'b0;
    int items_sent = 0;
    int cycles = 0;

    command_frame_receiver_queue #(.QUEUE_DEPTH(QDEPTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .rx_byte      (rx_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .event_res    (event_res),
        .command      (command),
        .queue_count  (queue_count)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("command_frame_receiver_queue_test: done, errors");
            $finish;
        end
    end

    // mostly short, a few long
    function automatic int pick_gap();
        int r;
        if (calm_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                shadow.check_event(event_res, command, queue_count);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                stall_left = pick_gap();
                if (stall_left > 0)
                begin
                    stall_left--;
                    result_stall <= 1'b1;
                end
                else
                    result_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(bit k, logic [7:0] b);
        int gap;
        item_valid <= 1'b1;
        kind       <= k;
        rx_byte    <= b;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        shadow.log_item(k, b);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_pop();
        send_item(1'b1, 8'($urandom_range(0, 255)));
    endtask

    // pop_after >= 0 slips a pop in behind that byte of the frame
    task automatic send_frame(frame_t fr, int pop_after);
        for (int i = 0; i < FRAME_LENGTH; i++)
        begin
            send_item(1'b0, fr[i]);
            if (i == pop_after)
                send_pop();
        end
    endtask

    task automatic build_frame(output frame_t fr, input int n);
        fr[0] = START_BYTE;
        fr[1] = 8'(n);
        fr[2] = ADDR_BYTE;
        fr[3] = ZERO_BYTE;
        fr[4] = ZERO_BYTE;
        fr[5] = 8'(CMD_BASE + n);
        fr[6] = END_BYTE;
    endtask

    task automatic random_frame(output frame_t fr);
        int r;
        int pos;
        build_frame(fr, $urandom_range(1, 7));
        r = $urandom_range(0, 99);
        if (r >= 70 && r < 85)
        begin
            case ($urandom_range(0, 3))
                0: pos = 2;
                1: pos = 3;
                2: pos = 4;
                default: pos = 6;
            endcase
            fr[pos] = 8'($urandom_range(0, 255));
        end
        else if (r >= 85 && r < 93)
        begin
            // zero or random command byte with a matching check byte
            fr[1] = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255));
            fr[5] = 8'(CMD_BASE + fr[1]);
        end
        else if (r >= 93)
            fr[5] = 8'($urandom_range(0, 255));
    endtask

    task automatic wait_for_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (shadow.pending() > 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        frame_t fr;
        int     start;
        int     r;
        shadow = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pop while a frame is half built, on an empty queue; then a zero command, a bad end byte and pops
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        build_frame(fr, 7);
        send_frame(fr, 3);
        build_frame(fr, 0);
        send_frame(fr, -1);
        build_frame(fr, 1);
        fr[6] = 8'h00;
        send_frame(fr, -1);
        repeat (4) send_pop();

        for (int chunk = 0; chunk < 6; chunk++)
        begin
            calm_phase = (chunk == 1);
            start = items_sent;
            if (chunk == 2)
            begin
                // sink holds off while frames pile up past the queue depth
                calm_phase   = 1'b1;
                hold_request = 1'b1;
                for (int i = 0; i < QDEPTH + 2; i++)
                begin
                    random_frame(fr);
                    send_frame(fr, -1);
                end
                calm_phase = 1'b0;
                repeat (QDEPTH + 2) send_pop();
            end
            if (chunk == 4)
                wait_for_results();
            while (items_sent - start < CHUNK_ITEMS)
            begin
                r = $urandom_range(0, 99);
                if (r < 52)
                begin
                    random_frame(fr);
                    send_frame(fr, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : -1);
                end
                else if (r < 88)
                    send_pop();
                else
                    send_item(1'b0, 8'($urandom_range(0, 255)));
            end
        end

        wait_for_results();
        repeat (DRAIN) @(posedge clk);
        if (shadow.errors == 0)
            $display("command_frame_receiver_queue_test: done, clean");
        else
            $display("command_frame_receiver_queue_test: done, errors");
        $finish;
    end

endmodule
